### sv/salru_pkg.sv
// shared types and constants for the set-associative lru tag lookup
// no dependencies; imported by salru_ctrl, salru_dp and the top level
package salru_pkg;

    localparam int IN_SET_W  = 6;
    localparam int IN_TAG_W  = 20;
    localparam int OUTCOME_W = 2;
    localparam int WAY_OUT_W = 2;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_COLD     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CONFLICT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr_step;     // write one reset row of the metadata memory
        logic lookup_read;  // capture the word and read its set
        logic commit;       // update the set and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;     // clearing pass is at its last row
        logic out_free;     // result register can take a word this cycle
    } t_status;

endpackage

### sv/salru_ctrl.sv
// sequencer for the lru tag lookup: clearing pass, accept, commit
// depends on salru_pkg
module salru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  salru_pkg::t_status i_status,
    output salru_pkg::t_cmd    o_cmd
);
    import salru_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.lookup_read = 1'b1;
                    n_state           = S_LOOK;
                end
            end
            S_LOOK: begin
                // wait here while the previous result is still held
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.clr_step |-> !o_in_ready)
        else $error("word accepted during clearing pass");

    a_read_then_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.lookup_read |=> !o_in_ready)
        else $error("new word accepted before the pending one committed");

    a_commit_frees_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.commit |=> o_in_ready)
        else $error("input not reopened after commit");
`endif

endmodule

### sv/salru_dp.sv
// datapath of the lru tag lookup: tag and metadata memories, hit and victim
// selection, recency update, result register; depends on salru_pkg
module salru_dp #(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 4,
    parameter int TAG_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  salru_pkg::t_cmd                     i_cmd,
    output salru_pkg::t_status                  o_status,
    input  logic [salru_pkg::IN_SET_W-1:0]      i_set_index,
    input  logic [salru_pkg::IN_TAG_W-1:0]      i_tag,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [salru_pkg::OUTCOME_W-1:0]     o_outcome,
    output logic [salru_pkg::WAY_OUT_W-1:0]     o_way
);
    import salru_pkg::*;

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int META_W  = NUM_WAYS * (WAY_W + 1);
    localparam int ROW_T_W = NUM_WAYS * TAG_BITS;
    localparam int SET_IN_N = 1 << IN_SET_W;

    // set index folded into range, built at elaboration
    logic [SET_W-1:0] set_lut [SET_IN_N];
    for (genvar g = 0; g < SET_IN_N; g++) begin : g_set_lut
        assign set_lut[g] = SET_W'(g % NUM_SETS);
    end

    logic [TAG_BITS+IN_TAG_W-1:0] tag_ext;
    logic [TAG_BITS-1:0]          tag_cut;
    assign tag_ext = {{TAG_BITS{1'b0}}, i_tag};
    assign tag_cut = tag_ext[TAG_BITS-1:0];

    logic [META_W-1:0]  meta_mem [NUM_SETS];
    logic [ROW_T_W-1:0] tag_mem  [NUM_SETS];

    logic [SET_W-1:0]    r_clr_cnt;
    logic [SET_W-1:0]    r_set;
    logic [TAG_BITS-1:0] r_tag;
    logic [META_W-1:0]   r_meta_rd;
    logic [ROW_T_W-1:0]  r_tags_rd;

    logic                          r_out_valid;
    logic [OUTCOME_W-1:0]          r_outcome;
    logic [WAY_OUT_W-1:0]          r_way;

    logic [NUM_WAYS-1:0][WAY_W-1:0]    rank_rd;
    logic [NUM_WAYS-1:0]               valid_rd;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tags_rd;
    logic [NUM_WAYS-1:0][WAY_W-1:0]    rank_new;
    logic [NUM_WAYS-1:0][WAY_W-1:0]    rank_rst;
    logic [NUM_WAYS-1:0]               valid_new;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0] tags_new;
    logic [NUM_WAYS-1:0]               hit_vec;
    logic                              any_hit;
    logic                              any_inv;
    logic [WAY_W-1:0]                  hit_way;
    logic [WAY_W-1:0]                  inv_way;
    logic [WAY_W-1:0]                  lru_way;
    logic [WAY_W-1:0]                  used;
    logic [WAY_W-1:0]                  old_rank;
    logic [OUTCOME_W-1:0]              outcome;
    logic [WAY_W+WAY_OUT_W-1:0]        used_ext;
    logic                              out_free;

    assign {rank_rd, valid_rd} = r_meta_rd;
    assign tags_rd             = r_tags_rd;

    always_comb begin
        hit_vec = '0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            hit_vec[w]  = valid_rd[w] && (tags_rd[w] == r_tag);
            rank_rst[w] = WAY_W'(w);
            if (rank_rd[w] == WAY_W'(NUM_WAYS - 1)) begin
                lru_way = WAY_W'(w);
            end
        end
        // descending scan so the lowest index wins
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!valid_rd[w]) begin
                inv_way = WAY_W'(w);
            end
        end
        any_hit = |hit_vec;
        any_inv = ~&valid_rd;
        if (any_hit) begin
            used    = hit_way;
            outcome = OUTCOME_HIT;
        end else if (any_inv) begin
            used    = inv_way;
            outcome = OUTCOME_COLD;
        end else begin
            used    = lru_way;
            outcome = OUTCOME_CONFLICT;
        end
        old_rank = rank_rd[used];
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (WAY_W'(w) == used) begin
                rank_new[w]  = '0;
                valid_new[w] = 1'b1;
                tags_new[w]  = r_tag;
            end else begin
                rank_new[w]  = (rank_rd[w] < old_rank) ? rank_rd[w] + 1'b1 : rank_rd[w];
                valid_new[w] = valid_rd[w];
                tags_new[w]  = tags_rd[w];
            end
        end
    end

    assign used_ext = {{WAY_OUT_W{1'b0}}, used};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup_read) begin
            r_set <= set_lut[i_set_index];
            r_tag <= tag_cut;
        end
    end

    // metadata memory: valid bits and ranks of one set per row
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            meta_mem[r_clr_cnt] <= {rank_rst, {NUM_WAYS{1'b0}}};
        end else if (i_cmd.commit) begin
            meta_mem[r_set] <= {rank_new, valid_new};
        end
        if (i_cmd.lookup_read) begin
            r_meta_rd <= meta_mem[set_lut[i_set_index]];
        end
    end

    // tag memory, no reset: entries are only looked at behind a valid bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            tag_mem[r_set] <= tags_new;
        end
        if (i_cmd.lookup_read) begin
            r_tags_rd <= tag_mem[set_lut[i_set_index]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_outcome <= outcome;
            r_way     <= used_ext[WAY_OUT_W-1:0];
        end
    end

    assign o_status.clr_last = (r_clr_cnt == SET_W'(NUM_SETS - 1));
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_outcome;
    assign o_way             = r_way;

`ifndef SYNTHESIS
    a_commit_needs_slot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.commit |-> out_free)
        else $error("commit would overwrite an untaken result");

    a_conflict_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && outcome == OUTCOME_CONFLICT) |-> (&valid_rd))
        else $error("conflict miss with an invalid way in the set");

    a_commit_shows_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.commit |=> o_out_valid)
        else $error("result not presented after commit");
`endif

endmodule

### sv/set_associative_lru_lookup_core.sv
// Set-associative tag store with true-LRU replacement.
// Input channel (i_in_valid / o_in_ready) carries one access word: a set index
// and a tag. Output channel (o_out_valid / i_out_ready) returns one word per
// access: outcome (hit, cold miss, conflict miss) and the way hit or filled.
// The set index is folded modulo NUM_SETS, the tag cut to TAG_BITS bits.
// An accepted word has its set read from the memories into registers; at the
// commit step the set is compared, the victim chosen, the set written back
// and the result register loaded. A new word is taken only after the pending
// one has committed.
// The result sits in an output register, so the next word is accepted while
// the previous result waits; if the receiver stalls, the following word is
// held at its commit step until the register frees.
// After reset a clearing pass writes the valid bits and recency ranks of every
// set, one set per cycle; o_in_ready stays low meanwhile.
// Tags have no reset and are only compared behind their valid bits.
// depends on salru_pkg, salru_ctrl, salru_dp
module set_associative_lru_lookup_core #(
    parameter int NUM_SETS = 64,
    parameter int NUM_WAYS = 4,
    parameter int TAG_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [salru_pkg::IN_SET_W-1:0]  i_set_index,
    input  logic [salru_pkg::IN_TAG_W-1:0]  i_tag,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [salru_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [salru_pkg::WAY_OUT_W-1:0] o_way
);
    import salru_pkg::*;

    t_cmd    cmd;
    t_status status;

    salru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    salru_dp #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_set_index (i_set_index),
        .i_tag       (i_tag),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_outcome   (o_outcome),
        .o_way       (o_way)
    );

endmodule
